FILE: sv/heat_equation_stencil_engine_defines.svh
// assertion macros for the heat equation stencil engine
`ifndef HEAT_EQUATION_STENCIL_ENGINE_DEFINES_SVH
`define HEAT_EQUATION_STENCIL_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HSE_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hse: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HSE_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hse: next-cycle check failed");

`endif

FILE: sv/hse_pkg.sv
// shared types and constants for the heat equation stencil engine
`default_nettype none

package hse_pkg;

  // sizes
  localparam int CELLS_DEF  = 64;
  localparam int VAL_W      = 48;
  localparam int IDX_W      = 6;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 48;
  localparam int NCFG_W     = 7;
  // working word of a cell: holds lap, 3*lap, the dividend and then the remainder
  localparam int WK_W       = 54;
  // shift-add division by ten: seed, four refinements, remainder, fix
  localparam int DIV_CYC    = 7;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS = 2'd2;

  // cycles of the division by ten
  localparam logic [DIV_CNT_W-1:0] DV_SEED = 3'd0;
  localparam logic [DIV_CNT_W-1:0] DV_SH4  = 3'd1;
  localparam logic [DIV_CNT_W-1:0] DV_SH8  = 3'd2;
  localparam logic [DIV_CNT_W-1:0] DV_SH16 = 3'd3;
  localparam logic [DIV_CNT_W-1:0] DV_SH32 = 3'd4;
  localparam logic [DIV_CNT_W-1:0] DV_REM  = 3'd5;
  localparam logic [DIV_CNT_W-1:0] DV_FIX  = 3'd6;

  // reset values of the configuration registers
  localparam logic signed [VAL_W-1:0] BOUND_RST = 48'sd5898240000000;
  localparam logic [NCFG_W-1:0]       CELLS_RST = 7'd64;

  // phases of a time step, also the controller state
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LAP,
    PH_TRIPLE,
    PH_ABS,
    PH_DIV,
    PH_COMMIT
  } phase_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    phase_t                    phase;
    logic [DIV_CNT_W-1:0]      sub;
    logic                      load;
    logic                      rd;
    logic [IDX_W-1:0]          idx;
    logic signed [VAL_W-1:0]   wdata;
    logic signed [VAL_W-1:0]   left_b;
    logic signed [VAL_W-1:0]   right_b;
  } cell_ctl_t;

  // controller status seen by the top level
  typedef struct packed {
    logic busy;
    logic rd_pend;
    logic out_load;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: sv/heat_equation_stencil_engine.sv
// top level of the explicit 1-d heat equation stencil engine
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_func, in_cell_index, in_cell_value
//   out      output     out_valid / out_stall  out_read_value
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// a load is written into the addressed cell when it is taken; a read item is captured by the
// addressed cell and then loaded into the output register, held back while that register is
// stalled, and the next item is taken after that. a time step stalls the input after it is taken:
// laplacian, times three, magnitude, shift-add division by ten in every cell, then the row commit.
// reset (rst_n low, synchronous) clears the cells, the sequencer and the result valid flag.
// a stalled result holds in the output register while loads and steps keep flowing.
`default_nettype none

`include "heat_equation_stencil_engine_defines.svh"

module heat_equation_stencil_engine #(
  parameter int CELLS = hse_pkg::CELLS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [hse_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [hse_pkg::IDX_W-1:0]           in_cell_index,
  input  wire logic signed [hse_pkg::VAL_W-1:0]    in_cell_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [hse_pkg::VAL_W-1:0]         out_read_value,
  input  wire logic                                cfg_we,
  input  wire logic [hse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hse_pkg::CFG_W-1:0]           cfg_data
);

  localparam int VAL_W = hse_pkg::VAL_W;
  localparam int NCW   = hse_pkg::NCFG_W;
  localparam int NW    = ($clog2(CELLS + 1) > NCW) ? $clog2(CELLS + 1) : NCW;

  logic signed [VAL_W-1:0] left_b_r, right_b_r;
  logic [NCW-1:0]          ncells_r;
  logic [NW-1:0]           n_ext, n_eff;
  logic signed [VAL_W-1:0] out_read_value_r;
  logic signed [VAL_W-1:0] rd_or;
  logic signed [VAL_W-1:0] vals [CELLS];
  logic signed [VAL_W-1:0] rds  [CELLS];
  logic                    in_acc;
  hse_pkg::cell_ctl_t      ctl;
  hse_pkg::ctrl_stat_t     stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_b_r  <= hse_pkg::BOUND_RST;
      right_b_r <= hse_pkg::BOUND_RST;
      ncells_r  <= hse_pkg::CELLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hse_pkg::CFG_LEFT:  left_b_r  <= $signed(cfg_data[VAL_W-1:0]);
        hse_pkg::CFG_RIGHT: right_b_r <= $signed(cfg_data[VAL_W-1:0]);
        hse_pkg::CFG_CELLS: ncells_r  <= cfg_data[NCW-1:0];
        default: begin
        end
      endcase
    end
  end

  // cells in use, clamped to the row
  always_comb begin
    n_ext = NW'(ncells_r);
    if (n_ext < NW'(3)) begin
      n_eff = NW'(3);
    end else if (n_ext > NW'(CELLS)) begin
      n_eff = NW'(CELLS);
    end else begin
      n_eff = n_ext;
    end
  end

  // sequencer
  hse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_func       (in_func),
    .in_cell_index (in_cell_index),
    .in_cell_value (in_cell_value),
    .out_stall     (out_stall),
    .left_b        (left_b_r),
    .right_b       (right_b_r),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .ctl           (ctl),
    .stat          (stat)
  );

  // row of cells, each wired to its two neighbors
  for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
    logic signed [VAL_W-1:0] lft, rgt;
    if (gi == 0) begin : g_lft_edge
      assign lft = '0;
    end else begin : g_lft
      assign lft = vals[gi-1];
    end
    if (gi == CELLS - 1) begin : g_rgt_edge
      assign rgt = '0;
    end else begin : g_rgt
      assign rgt = vals[gi+1];
    end
    hse_cell #(
      .POS (gi),
      .NW  (NW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .n_eff   (n_eff),
      .left_i  (lft),
      .right_i (rgt),
      .value_o (vals[gi]),
      .rd_o    (rds[gi])
    );
  end

  // merge of the captured read values, only the addressed cell is nonzero
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CELLS; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (stat.out_load) begin
      out_read_value_r <= rd_or;
    end
  end

  assign out_read_value = out_read_value_r;

  // input item taken in this cycle
  assign in_acc = in_valid && !in_stall;

  // a taken read is pending in the next cycle
  `HSE_ASSERT_NXT(a_read_pends, in_acc && (in_func == hse_pkg::FUNC_READ), stat.rd_pend)
  // a taken step keeps the input side stalled in the next cycle
  `HSE_ASSERT_NXT(a_step_busy, in_acc && (in_func == hse_pkg::FUNC_STEP), stat.busy && in_stall)
  // a step never overlaps a pending read
  `HSE_ASSERT_IMP(a_no_overlap, stat.busy, !stat.rd_pend)
  // the result register is loaded only into a free or draining slot
  `HSE_ASSERT_IMP(a_load_free, stat.out_load, !out_valid || !out_stall)

endmodule

`default_nettype wire

FILE: sv/hse_cell.sv
// one grid cell: holds its value and performs its share of a time step
`default_nettype none

module hse_cell #(
  parameter int POS = 0,
  parameter int NW  = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire hse_pkg::cell_ctl_t                   ctl,
  input  wire logic [NW-1:0]                        n_eff,
  input  wire logic signed [hse_pkg::VAL_W-1:0]     left_i,
  input  wire logic signed [hse_pkg::VAL_W-1:0]     right_i,
  output logic signed [hse_pkg::VAL_W-1:0]          value_o,
  output logic signed [hse_pkg::VAL_W-1:0]          rd_o
);

  localparam int VAL_W = hse_pkg::VAL_W;
  localparam int WK_W  = hse_pkg::WK_W;
  localparam int SW    = VAL_W + 2;
  localparam logic signed [SW-1:0] SMAX = {3'b000, {(VAL_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {3'b111, {(VAL_W-1){1'b0}}};
  localparam logic [NW-1:0] POS_N = NW'(POS);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic signed [VAL_W-1:0] rd_r;
  logic signed [WK_W-1:0]  wk_r, wk_nxt;
  logic [WK_W-1:0]         acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic                    hit;
  logic                    is_last;
  logic                    is_inner;

  // address match for loads and reads
  assign hit = (POS < (1 << hse_pkg::IDX_W)) && (ctl.idx == hse_pkg::IDX_W'(POS));

  // role of this cell in the current row
  assign is_last  = (POS_N == n_eff - NW'(1));
  assign is_inner = (POS != 0) && (POS_N < n_eff - NW'(1));

  // step datapath: laplacian, times three, magnitude plus rounding, divide by ten
  always_comb begin
    logic [WK_W-1:0]         uwk;
    logic [WK_W-1:0]         q3;
    logic [VAL_W-1:0]        q;
    logic signed [SW-1:0]    qs;
    logic signed [SW-1:0]    sum;
    logic signed [VAL_W-1:0] sat;
    wk_nxt    = wk_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    value_nxt = value_r;
    uwk       = wk_r;
    q3        = acc_r >> 3;
    q         = acc_r[VAL_W-1:0];
    qs        = $signed({2'b00, q});
    sum       = SW'(value_r) + (neg_r ? -qs : qs);
    if (sum > SMAX) begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum < SMIN) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = sum[VAL_W-1:0];
    end
    case (ctl.phase)
      hse_pkg::PH_IDLE: begin
        if (ctl.load && hit) begin
          value_nxt = ctl.wdata;
        end
      end
      hse_pkg::PH_LAP: begin
        wk_nxt = WK_W'(left_i) + WK_W'(right_i) - (WK_W'(value_r) <<< 1);
      end
      hse_pkg::PH_TRIPLE: begin
        wk_nxt = wk_r + (wk_r <<< 1);
      end
      hse_pkg::PH_ABS: begin
        neg_nxt = wk_r[WK_W-1];
        wk_nxt  = wk_r[WK_W-1] ? (~wk_r + WK_W'(6)) : (wk_r + WK_W'(5));
      end
      hse_pkg::PH_DIV: begin
        // times 0.8 by shift-add, then divide by eight and fix up from the remainder
        case (ctl.sub)
          hse_pkg::DV_SEED: acc_nxt = (uwk >> 1) + (uwk >> 2);
          hse_pkg::DV_SH4:  acc_nxt = acc_r + (acc_r >> 4);
          hse_pkg::DV_SH8:  acc_nxt = acc_r + (acc_r >> 8);
          hse_pkg::DV_SH16: acc_nxt = acc_r + (acc_r >> 16);
          hse_pkg::DV_SH32: acc_nxt = acc_r + (acc_r >> 32);
          hse_pkg::DV_REM: begin
            acc_nxt = q3;
            wk_nxt  = $signed(uwk - (q3 << 3) - (q3 << 1));
          end
          hse_pkg::DV_FIX:  acc_nxt = acc_r + WK_W'(uwk > WK_W'(9));
          default: begin
          end
        endcase
      end
      hse_pkg::PH_COMMIT: begin
        if (POS == 0) begin
          value_nxt = ctl.left_b;
        end else if (is_last) begin
          value_nxt = ctl.right_b;
        end else if (is_inner) begin
          value_nxt = sat;
        end
      end
      default: begin
      end
    endcase
  end

  // cell value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  // working registers and read capture
  always_ff @(posedge clk) begin
    wk_r  <= wk_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    if (ctl.rd) begin
      rd_r <= hit ? value_r : '0;
    end
  end

  assign value_o = value_r;
  assign rd_o    = rd_r;

endmodule

`default_nettype wire

FILE: sv/hse_ctrl.sv
// step sequencer, item handshake and result hand-off
`default_nettype none

module hse_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic [hse_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [hse_pkg::IDX_W-1:0]           in_cell_index,
  input  wire logic signed [hse_pkg::VAL_W-1:0]    in_cell_value,
  input  wire logic                                out_stall,
  input  wire logic signed [hse_pkg::VAL_W-1:0]    left_b,
  input  wire logic signed [hse_pkg::VAL_W-1:0]    right_b,
  output logic                                     in_stall,
  output logic                                     out_valid,
  output hse_pkg::cell_ctl_t                       ctl,
  output hse_pkg::ctrl_stat_t                      stat
);

  localparam int CW = hse_pkg::DIV_CNT_W;

  hse_pkg::phase_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_load;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hse_pkg::PH_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and broadcast to the cells
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_stall    = (state_r != hse_pkg::PH_IDLE) || rd_pend_r;
    accept      = in_valid && !in_stall;
    out_load    = rd_pend_r && (!out_valid_r || !out_stall);
    rd_pend_nxt = rd_pend_r;
    if (accept && (in_func == hse_pkg::FUNC_READ)) begin
      rd_pend_nxt = 1'b1;
    end else if (out_load) begin
      rd_pend_nxt = 1'b0;
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);

    ctl.phase   = state_r;
    ctl.sub     = cnt_r;
    ctl.load    = accept && (in_func == hse_pkg::FUNC_LOAD);
    ctl.rd      = accept && (in_func == hse_pkg::FUNC_READ);
    ctl.idx     = in_cell_index;
    ctl.wdata   = in_cell_value;
    ctl.left_b  = left_b;
    ctl.right_b = right_b;

    unique case (state_r)
      hse_pkg::PH_IDLE: begin
        if (accept && (in_func == hse_pkg::FUNC_STEP)) begin
          state_nxt = hse_pkg::PH_LAP;
        end
      end
      hse_pkg::PH_LAP: begin
        state_nxt = hse_pkg::PH_TRIPLE;
      end
      hse_pkg::PH_TRIPLE: begin
        state_nxt = hse_pkg::PH_ABS;
      end
      hse_pkg::PH_ABS: begin
        state_nxt = hse_pkg::PH_DIV;
        cnt_nxt   = '0;
      end
      hse_pkg::PH_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(hse_pkg::DIV_CYC - 1)) begin
          state_nxt = hse_pkg::PH_COMMIT;
        end
      end
      hse_pkg::PH_COMMIT: begin
        state_nxt = hse_pkg::PH_IDLE;
      end
      default: begin
        state_nxt = hse_pkg::PH_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign stat.busy     = (state_r != hse_pkg::PH_IDLE);
  assign stat.rd_pend  = rd_pend_r;
  assign stat.out_load = out_load;

endmodule

`default_nettype wire
